/* rtl/core/bdq_pkg.sv */
// shared types, widths and codes for the bounded deque with positional edit
package bdq_pkg;

    localparam int CAPACITY    = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int POS_W       = 8;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int IN_TDATA_W  = ((OP_W + POS_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STATUS_W + DATA_W + COUNT_W + 7) / 8) * 8;

    // remainder unit retires two quotient bits per cycle
    localparam int MOD_STEPS  = POS_W / 2;
    localparam int MOD_STEP_W = $clog2(MOD_STEPS);
    localparam int MOD_SH_W   = $clog2(POS_W);
    localparam int MOD_WIDE_W = POS_W + CNT_W;

    localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_LOAD,
        ACT_LEFT,
        ACT_RIGHT
    } cell_act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] remainder;
    } mod_rsp_t;

endpackage

/* rtl/core/bdq_cell.sv */
// one storage cell of the element row, loads or takes a neighbor's word
module bdq_cell (
    input  logic                       aclk,
    input  bdq_pkg::cell_act_t         act,
    input  logic [bdq_pkg::DATA_W-1:0] new_value,
    input  logic [bdq_pkg::DATA_W-1:0] left_value,
    input  logic [bdq_pkg::DATA_W-1:0] right_value,
    output logic [bdq_pkg::DATA_W-1:0] value
);

    logic [bdq_pkg::DATA_W-1:0] value_reg;
    logic [bdq_pkg::DATA_W-1:0] value_next;

    always_comb begin
        case (act)
            bdq_pkg::ACT_LOAD:  value_next = new_value;
            bdq_pkg::ACT_LEFT:  value_next = left_value;
            bdq_pkg::ACT_RIGHT: value_next = right_value;
            default:            value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* rtl/core/bdq_mod.sv */
// iterative remainder unit, two conditional subtracts per cycle
module bdq_mod (
    input  logic              aclk,
    input  logic              aresetn,
    input  bdq_pkg::mod_req_t req,
    output bdq_pkg::mod_rsp_t rsp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [bdq_pkg::MOD_STEP_W-1:0]   step_reg, step_next;
    logic [bdq_pkg::POS_W-1:0]        rem_reg, rem_next;
    logic [bdq_pkg::CNT_W-1:0]        div_reg, div_next;
    logic [bdq_pkg::MOD_WIDE_W-1:0]   d_hi, d_lo;
    logic [bdq_pkg::POS_W-1:0]        rem_mid;

    always_comb begin
        d_hi = bdq_pkg::MOD_WIDE_W'(div_reg) << {step_reg, 1'b1};
        d_lo = bdq_pkg::MOD_WIDE_W'(div_reg) << {step_reg, 1'b0};
        rem_mid = rem_reg;
        if (bdq_pkg::MOD_WIDE_W'(rem_reg) >= d_hi) begin
            rem_mid = rem_reg - d_hi[bdq_pkg::POS_W-1:0];
        end

        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = bdq_pkg::MOD_STEP_W'(bdq_pkg::MOD_STEPS - 1);
            rem_next  = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = rem_mid;
            if (bdq_pkg::MOD_WIDE_W'(rem_mid) >= d_lo) begin
                rem_next = rem_mid - d_lo[bdq_pkg::POS_W-1:0];
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[bdq_pkg::IDX_W-1:0];

endmodule

/* rtl/core/bounded_deque_positional_edit.sv */
// bounded deque with insert and delete at the ends or at a position
//
//  channel | dir | fields (lowest bit up)
//  s_      | in  | operation[2:0] position[10:3] value[42:11]
//  m_      | out | status[1:0] removed_value[33:2] element_count[40:34]
//
// an item is accepted, then applied; its word is valid right after apply
// delete-at with a position above one on a non-empty deque also waits for the remainder
// unit (4 steps of 2 bits/cycle, then its registered done flag)
// the elements from the edit position onward shift by one cell, all in the apply cycle
// reset clears the count and the handshake state; cell contents stay stale
// a waiting result does not block the next accept, only its apply cycle
module bounded_deque_positional_edit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation, position, value
    input  logic [bdq_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, removed_value, element_count
    output logic [bdq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    bdq_pkg::state_t                  state_reg, state_next;
    logic [bdq_pkg::OP_W-1:0]         op_reg, op_next;
    logic [bdq_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [bdq_pkg::DATA_W-1:0]       val_reg, val_next;
    logic [bdq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                             m_valid_reg, m_valid_next;
    logic [bdq_pkg::STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [bdq_pkg::DATA_W-1:0]       m_removed_reg, m_removed_next;
    logic [bdq_pkg::COUNT_W-1:0]      m_count_reg, m_count_next;

    logic [bdq_pkg::OP_W-1:0]         in_op;
    logic [bdq_pkg::POS_W-1:0]        in_pos;
    logic [bdq_pkg::DATA_W-1:0]       in_val;
    logic                             accept, need_mod;
    logic                             is_ins, is_del, full, empty;
    logic                             apply_fire, do_ins, do_del;
    logic [bdq_pkg::POS_W-1:0]        lim, want, sel;
    logic [bdq_pkg::IDX_W-1:0]        edit_idx;
    logic [bdq_pkg::CNT_W-1:0]        count_m1;

    bdq_pkg::mod_req_t                mod_req;
    bdq_pkg::mod_rsp_t                mod_rsp;

    bdq_pkg::cell_act_t               act [bdq_pkg::CAPACITY];
    logic [bdq_pkg::DATA_W-1:0]       cell_q [bdq_pkg::CAPACITY];

    assign in_op  = s_tdata[bdq_pkg::OP_W-1:0];
    assign in_pos = s_tdata[bdq_pkg::OP_W +: bdq_pkg::POS_W];
    assign in_val = s_tdata[bdq_pkg::OP_W + bdq_pkg::POS_W +: bdq_pkg::DATA_W];

    assign s_tready = (state_reg == bdq_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // only a delete-at past the first position needs the remainder
    assign need_mod = (in_op == bdq_pkg::OP_DEL_AT) && (count_reg != '0) && (in_pos > 8'd1);

    assign mod_req.start    = accept && need_mod;
    assign mod_req.dividend = in_pos - 1'b1;
    assign mod_req.divisor  = count_reg;

    bdq_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    always_comb begin
        is_ins = (op_reg == bdq_pkg::OP_INS_REAR) || (op_reg == bdq_pkg::OP_INS_FRONT)
              || (op_reg == bdq_pkg::OP_INS_AT);
        is_del = (op_reg == bdq_pkg::OP_DEL_REAR) || (op_reg == bdq_pkg::OP_DEL_FRONT)
              || (op_reg == bdq_pkg::OP_DEL_AT);
        full   = (count_reg == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
        empty  = (count_reg == '0);
        count_m1 = count_reg - 1'b1;

        // insert-at lands at 1 + max(0, min(pos-1, count-2))
        lim  = bdq_pkg::POS_W'(count_m1);
        want = (pos_reg == '0) ? 8'd1 : pos_reg;
        sel  = (want < lim) ? want : lim;
        if (sel == '0) begin
            sel = 8'd1;
        end

        edit_idx = '0;
        if (is_ins) begin
            if (op_reg == bdq_pkg::OP_INS_REAR) begin
                edit_idx = count_reg[bdq_pkg::IDX_W-1:0];
            end else if (op_reg == bdq_pkg::OP_INS_FRONT || empty) begin
                edit_idx = '0;
            end else begin
                edit_idx = sel[bdq_pkg::IDX_W-1:0];
            end
        end else begin
            if (op_reg == bdq_pkg::OP_DEL_REAR) begin
                edit_idx = count_m1[bdq_pkg::IDX_W-1:0];
            end else if (op_reg == bdq_pkg::OP_DEL_FRONT || pos_reg <= 8'd1) begin
                edit_idx = '0;
            end else begin
                edit_idx = mod_rsp.remainder;
            end
        end

        apply_fire = (state_reg == bdq_pkg::ST_APPLY) && (!m_valid_reg || m_tready);
        do_ins     = apply_fire && is_ins && !full;
        do_del     = apply_fire && is_del && !empty;
    end

    // per-cell moves: insert opens a gap at edit_idx, delete closes it
    for (genvar i = 0; i < bdq_pkg::CAPACITY; i++) begin : g_cell
        always_comb begin
            act[i] = bdq_pkg::ACT_HOLD;
            if (do_ins) begin
                if (bdq_pkg::IDX_W'(i) == edit_idx) begin
                    act[i] = bdq_pkg::ACT_LOAD;
                end else if (bdq_pkg::IDX_W'(i) > edit_idx
                             && bdq_pkg::CNT_W'(i) <= count_reg) begin
                    act[i] = bdq_pkg::ACT_LEFT;
                end
            end else if (do_del) begin
                if (bdq_pkg::IDX_W'(i) >= edit_idx
                    && bdq_pkg::CNT_W'(i + 1) < count_reg) begin
                    act[i] = bdq_pkg::ACT_RIGHT;
                end
            end
        end

        bdq_cell u_cell (
            .aclk        (aclk),
            .act         (act[i]),
            .new_value   (val_reg),
            .left_value  ((i == 0) ? val_reg : cell_q[(i == 0) ? 0 : i - 1]),
            .right_value ((i == bdq_pkg::CAPACITY - 1) ? val_reg
                          : cell_q[(i == bdq_pkg::CAPACITY - 1) ? i : i + 1]),
            .value       (cell_q[i])
        );
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_removed_next = m_removed_reg;
        m_count_next   = m_count_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bdq_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next    = in_op;
                    pos_next   = in_pos;
                    val_next   = in_val;
                    state_next = need_mod ? bdq_pkg::ST_MOD : bdq_pkg::ST_APPLY;
                end
            end
            bdq_pkg::ST_MOD: begin
                if (mod_rsp.done) begin
                    state_next = bdq_pkg::ST_APPLY;
                end
            end
            bdq_pkg::ST_APPLY: begin
                if (apply_fire) begin
                    m_status_next  = bdq_pkg::STAT_DONE;
                    m_removed_next = '0;
                    if (is_ins && full) begin
                        m_status_next = bdq_pkg::STAT_FULL;
                    end else if (is_del && empty) begin
                        m_status_next = bdq_pkg::STAT_EMPTY;
                    end else if (do_ins) begin
                        count_next = count_reg + 1'b1;
                    end else if (do_del) begin
                        count_next     = count_m1;
                        m_removed_next = cell_q[edit_idx];
                    end
                    m_count_next = bdq_pkg::COUNT_W'(count_next);
                    m_valid_next = 1'b1;
                    state_next   = bdq_pkg::ST_IDLE;
                end
            end
            default: state_next = bdq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bdq_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        m_status_reg  <= m_status_next;
        m_removed_reg <= m_removed_next;
        m_count_reg   <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = bdq_pkg::OUT_TDATA_W'({m_count_reg, m_removed_reg, m_status_reg});

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bdq_pkg::CNT_W'(bdq_pkg::CAPACITY))
        else $error("element count above capacity");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == bdq_pkg::STAT_FULL
        |-> m_count_reg == bdq_pkg::COUNT_W'(bdq_pkg::CAPACITY))
        else $error("full status with list not full");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == bdq_pkg::STAT_EMPTY |-> m_count_reg == '0)
        else $error("empty status with elements held");

    a_mod_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bdq_pkg::ST_MOD && !mod_rsp.done |=> state_reg == bdq_pkg::ST_MOD)
        else $error("left remainder wait before unit finished");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !apply_fire |=> count_reg == $past(count_reg))
        else $error("count changed outside apply cycle");

endmodule

/* test/bounded_deque_positional_edit_test.sv */
// testbench for the bounded deque: directed rows, then random edits checked against a shadow deque
module bounded_deque_positional_edit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // codes the block ignores
    localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [bdq_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS  = 600;
    localparam int CALM_WORDS    = 80;
    localparam int HOLD_OFF_AT   = 60;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int DRAIN_CYCLES  = 12;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        logic [bdq_pkg::STATUS_W-1:0] status;
        logic [bdq_pkg::DATA_W-1:0]   removed;
        logic [bdq_pkg::COUNT_W-1:0]  count;
    } deque_result_t;

    typedef struct packed {
        logic [bdq_pkg::OP_W-1:0]     op;
        logic [bdq_pkg::POS_W-1:0]    pos;
        logic [bdq_pkg::DATA_W-1:0]   val;
        int                           reps;
        bit                           known;
        logic [bdq_pkg::STATUS_W-1:0] status;
        logic [bdq_pkg::DATA_W-1:0]   removed;
        logic [bdq_pkg::COUNT_W-1:0]  count;
    } directed_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bdq_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bdq_pkg::OUT_TDATA_W-1:0] m_tdata;

    // shadow copy of the deque contents
    logic [bdq_pkg::DATA_W-1:0] deque_cells [bdq_pkg::CAPACITY];
    int                         deque_len = 0;

    deque_result_t pending_results [$];
    int            mismatches = 0;
    int            results_seen = 0;
    bit            quiet = 1'b0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{bdq_pkg::OP_DEL_REAR,  8'd0,   32'h0000_0000, 1,  1'b1,
          bdq_pkg::STAT_EMPTY, 32'h0, 7'd0},
        '{bdq_pkg::OP_DEL_FRONT, 8'd255, 32'hffff_ffff, 1,  1'b1,
          bdq_pkg::STAT_EMPTY, 32'h0, 7'd0},
        '{bdq_pkg::OP_DEL_AT,    8'd255, 32'h0000_0000, 1,  1'b1,
          bdq_pkg::STAT_EMPTY, 32'h0, 7'd0},
        '{OP_SPARE_HI,           8'd255, 32'hffff_ffff, 1,  1'b1,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_INS_AT,    8'd0,   32'h8000_0000, 1,  1'b1,
          bdq_pkg::STAT_DONE,  32'h0, 7'd1},
        '{bdq_pkg::OP_DEL_AT,    8'd1,   32'h0000_0000, 1,  1'b1,
          bdq_pkg::STAT_DONE,  32'h8000_0000, 7'd0},
        '{bdq_pkg::OP_INS_AT,    8'd255, 32'h7fff_ffff, 1,  1'b1,
          bdq_pkg::STAT_DONE,  32'h0, 7'd1},
        '{bdq_pkg::OP_INS_AT,    8'd255, 32'h1234_5678, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_INS_FRONT, 8'd0,   32'h8000_0000, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_INS_REAR,  8'd0,   32'h0000_0001, 13, 1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_INS_REAR,  8'd0,   32'hffff_ffff, 1,  1'b1,
          bdq_pkg::STAT_FULL,  32'h0, 7'd16},
        '{bdq_pkg::OP_INS_FRONT, 8'd255, 32'h0000_0000, 1,  1'b1,
          bdq_pkg::STAT_FULL,  32'h0, 7'd16},
        '{bdq_pkg::OP_INS_AT,    8'd128, 32'h5555_aaaa, 1,  1'b1,
          bdq_pkg::STAT_FULL,  32'h0, 7'd16},
        '{OP_SPARE_LO,           8'd0,   32'h0000_0000, 1,  1'b1,
          bdq_pkg::STAT_DONE,  32'h0, 7'd16},
        '{bdq_pkg::OP_DEL_AT,    8'd255, 32'h0000_0000, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_DEL_AT,    8'd2,   32'h0000_0000, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_INS_AT,    8'd1,   32'hdead_beef, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_INS_AT,    8'd255, 32'h0bad_f00d, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_DEL_AT,    8'd0,   32'h0000_0000, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_DEL_FRONT, 8'd0,   32'h0000_0000, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_DEL_REAR,  8'd0,   32'h0000_0000, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0},
        '{bdq_pkg::OP_DEL_AT,    8'd17,  32'h0000_0000, 1,  1'b0,
          bdq_pkg::STAT_DONE,  32'h0, 7'd0}
    };

    bounded_deque_positional_edit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // apply one edit to the shadow deque and return what the block should report
    function automatic deque_result_t apply_edit(input logic [bdq_pkg::OP_W-1:0] op,
                                                 input logic [bdq_pkg::POS_W-1:0] pos,
                                                 input logic [bdq_pkg::DATA_W-1:0] val);
        deque_result_t res;
        int            slot;
        res = '{bdq_pkg::STAT_DONE, '0, '0};
        case (op)
            bdq_pkg::OP_INS_REAR, bdq_pkg::OP_INS_FRONT, bdq_pkg::OP_INS_AT: begin
                if (deque_len >= bdq_pkg::CAPACITY) begin
                    res.status = bdq_pkg::STAT_FULL;
                end else begin
                    if (op == bdq_pkg::OP_INS_REAR) begin
                        slot = deque_len;
                    end else if (op == bdq_pkg::OP_INS_FRONT || deque_len == 0) begin
                        slot = 0;
                    end else begin
                        // never the new front, never past the rear
                        slot = int'(pos) - 1;
                        if (slot > deque_len - 2) slot = deque_len - 2;
                        if (slot < 0) slot = 0;
                        slot = slot + 1;
                    end
                    for (int i = deque_len; i > slot; i--) deque_cells[i] = deque_cells[i-1];
                    deque_cells[slot] = val;
                    deque_len++;
                end
            end
            bdq_pkg::OP_DEL_REAR, bdq_pkg::OP_DEL_FRONT, bdq_pkg::OP_DEL_AT: begin
                if (deque_len == 0) begin
                    res.status = bdq_pkg::STAT_EMPTY;
                end else begin
                    if (op == bdq_pkg::OP_DEL_REAR) slot = deque_len - 1;
                    else if (op == bdq_pkg::OP_DEL_FRONT || pos <= 1) slot = 0;
                    else slot = (int'(pos) - 1) % deque_len;
                    res.removed = deque_cells[slot];
                    for (int i = slot; i + 1 < deque_len; i++) deque_cells[i] = deque_cells[i+1];
                    deque_len--;
                end
            end
            default: ;
        endcase
        res.count = bdq_pkg::COUNT_W'(deque_len);
        return res;
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic offer_word(input logic [bdq_pkg::OP_W-1:0] op,
                              input logic [bdq_pkg::POS_W-1:0] pos,
                              input logic [bdq_pkg::DATA_W-1:0] val, input bit known,
                              input deque_result_t typed);
        logic [bdq_pkg::IN_TDATA_W-1:0] word;
        deque_result_t                  predicted;
        word = '0;
        word[bdq_pkg::OP_W-1:0] = op;
        word[bdq_pkg::OP_W+:bdq_pkg::POS_W] = pos;
        word[bdq_pkg::OP_W+bdq_pkg::POS_W+:bdq_pkg::DATA_W] = val;
        s_tdata <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = apply_edit(op, pos, val);
        pending_results.push_back(known ? typed : predicted);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= bdq_pkg::IN_TDATA_W'({$urandom, $urandom});
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
    endtask

    always @(posedge aclk) begin : check_results
        deque_result_t want;
        deque_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[bdq_pkg::STATUS_W-1:0];
            got.removed = m_tdata[bdq_pkg::STATUS_W+:bdq_pkg::DATA_W];
            got.count = m_tdata[bdq_pkg::STATUS_W+bdq_pkg::DATA_W+:bdq_pkg::COUNT_W];
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding: status %0d removed %h count %0d",
                       got.status, got.removed, got.count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.removed !== want.removed) begin
                    $error("removed_value: expected %h, got %h", want.removed, got.removed);
                    mismatches++;
                end
                if (got.count !== want.count) begin
                    $error("element_count: expected %0d, got %0d", want.count, got.count);
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    // result side: random stalls plus one long hold-off to back the deque up
    initial begin : result_side
        bit hold_off_done;
        hold_off_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_off_done && !quiet && results_seen >= HOLD_OFF_AT) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN - 1) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : sender
        deque_result_t                typed;
        logic [bdq_pkg::OP_W-1:0]     op;
        logic [bdq_pkg::POS_W-1:0]    pos;
        logic [bdq_pkg::DATA_W-1:0]   val;
        int                           counted;
        int                           pick;
        bit                           filling;
        counted = 0;
        filling = 1'b1;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[r]) begin
            typed = '{directed_rows[r].status, directed_rows[r].removed, directed_rows[r].count};
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                offer_word(directed_rows[r].op, directed_rows[r].pos,
                           directed_rows[r].val + bdq_pkg::DATA_W'(k) * 32'h0101_0101,
                           directed_rows[r].known, typed);
            end
        end

        while (counted < RANDOM_WORDS) begin
            // sweep the fill level between empty and full
            if (deque_len == bdq_pkg::CAPACITY) filling = 1'b0;
            else if (deque_len == 0) filling = 1'b1;
            else if ($urandom_range(0, 29) == 0) filling = !filling;
            quiet = (counted >= RANDOM_WORDS - CALM_WORDS);

            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                op = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
            end else if ($urandom_range(0, 99) < (filling ? 70 : 30)) begin
                case ($urandom_range(0, 2))
                    0: op = bdq_pkg::OP_INS_REAR;
                    1: op = bdq_pkg::OP_INS_FRONT;
                    default: op = bdq_pkg::OP_INS_AT;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0: op = bdq_pkg::OP_DEL_REAR;
                    1: op = bdq_pkg::OP_DEL_FRONT;
                    default: op = bdq_pkg::OP_DEL_AT;
                endcase
            end

            case ($urandom_range(0, 9))
                0: pos = '0;
                1: pos = 8'd1;
                2, 3, 4, 5, 6: pos = bdq_pkg::POS_W'($urandom_range(0, deque_len + 2));
                default: pos = bdq_pkg::POS_W'($urandom_range(0, 255));
            endcase

            case ($urandom_range(0, 15))
                0: val = 32'h8000_0000;
                1: val = 32'h7fff_ffff;
                2: val = '0;
                3: val = '1;
                default: val = $urandom;
            endcase

            offer_word(op, pos, val, 1'b0, typed);
            if (op != OP_SPARE_LO && op != OP_SPARE_HI) counted++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("bounded_deque_positional_edit test passed");
        end else begin
            $display("bounded_deque_positional_edit test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("bounded_deque_positional_edit test failed");
        $finish;
    end

endmodule
